### rtl/core/huf_pkg.sv
// Shared constants, request and result codes, and controller/datapath interface types.
package huf_pkg;

    localparam int SYM_W    = 8;
    localparam int WEIGHT_W = 24;
    localparam int CODE_W   = 63;
    localparam int LEN_W    = 6;
    localparam int DEPTH_W  = 8;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_DECODE = 2'd2;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_DECODE = 2'd2;

    typedef struct packed {
        logic latch;
        logic load;
        logic build_init;
        logic scan_init;
        logic mscan;
        logic mw1;
        logic mw2;
        logic code_init;
        logic leaf_init;
        logic par_rd;
        logic code_up;
        logic code_wr;
        logic walk_root;
        logic escan;
        logic erd;
        logic sel_first;
        logic dstep;
        logic dec_leaf;
        logic dec_move;
        logic dsrd;
        logic emit_done;
        logic emit_ehit;
        logic emit_emiss;
        logic emit_dnone;
        logic emit_dsym;
    } huf_cmd_t;

    typedef struct packed {
        logic req_load;
        logic req_encode;
        logic req_decode;
        logic last;
        logic built;
        logic n_zero;
        logic n_one;
        logic merge_end;
        logic scan_end;
        logic leaves_end;
        logic c_has_parent;
        logic enc_hit;
        logic enc_end;
        logic dec_bad;
        logic dec_leaf;
    } huf_stat_t;

endpackage

### rtl/core/huf_ctrl.sv
// Controller state machine sequencing loads, tree build, encode and decode.
module huf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  huf_pkg::huf_stat_t   stat,
    output huf_pkg::huf_cmd_t    cmd
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_BINIT = 17'b00000000000000010,
        S_MCHK  = 17'b00000000000000100,
        S_MSCAN = 17'b00000000000001000,
        S_MW1   = 17'b00000000000010000,
        S_MW2   = 17'b00000000000100000,
        S_CLEAF = 17'b00000000001000000,
        S_CCHK  = 17'b00000000010000000,
        S_CUP   = 17'b00000000100000000,
        S_BDONE = 17'b00000001000000000,
        S_ESCAN = 17'b00000010000000000,
        S_ERD   = 17'b00000100000000000,
        S_EOUT  = 17'b00001000000000000,
        S_DSTEP = 17'b00010000000000000,
        S_DNEXT = 17'b00100000000000000,
        S_DSRD  = 17'b01000000000000000,
        S_DSOUT = 17'b10000000000000000
    } huf_state_t;

    huf_state_t state_reg;
    huf_state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (stat.req_load)
                    begin
                        cmd.load = 1'b1;
                        if (stat.last)
                            state_next = S_BINIT;
                    end
                    else if (stat.req_encode)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_ESCAN;
                    end
                    else if (stat.req_decode)
                    begin
                        if (!stat.built || stat.n_zero)
                            cmd.emit_dnone = 1'b1;
                        else if (stat.n_one)
                        begin
                            cmd.sel_first = 1'b1;
                            state_next    = S_DSRD;
                        end
                        else
                            state_next = S_DSTEP;
                    end
                end
            end
            S_BINIT:
            begin
                cmd.build_init = 1'b1;
                state_next     = stat.n_zero ? S_BDONE : S_MCHK;
            end
            S_MCHK:
            begin
                if (stat.merge_end)
                begin
                    cmd.code_init = 1'b1;
                    state_next    = S_CLEAF;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_MSCAN;
                end
            end
            S_MSCAN:
            begin
                cmd.mscan = 1'b1;
                if (stat.scan_end)
                    state_next = S_MW1;
            end
            S_MW1:
            begin
                cmd.mw1    = 1'b1;
                state_next = S_MW2;
            end
            S_MW2:
            begin
                cmd.mw2    = 1'b1;
                state_next = S_MCHK;
            end
            S_CLEAF:
            begin
                if (stat.leaves_end)
                    state_next = S_BDONE;
                else
                begin
                    cmd.leaf_init = 1'b1;
                    state_next    = S_CCHK;
                end
            end
            S_CCHK:
            begin
                if (stat.c_has_parent)
                begin
                    cmd.par_rd = 1'b1;
                    state_next = S_CUP;
                end
                else
                begin
                    cmd.code_wr = 1'b1;
                    state_next  = S_CLEAF;
                end
            end
            S_CUP:
            begin
                cmd.code_up = 1'b1;
                state_next  = S_CCHK;
            end
            S_BDONE:
            begin
                cmd.walk_root = 1'b1;
                cmd.emit_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_ESCAN:
            begin
                cmd.escan = 1'b1;
                if (stat.enc_hit)
                    state_next = S_ERD;
                else if (stat.enc_end)
                begin
                    cmd.emit_emiss = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ERD:
            begin
                cmd.erd    = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                cmd.emit_ehit = 1'b1;
                state_next    = S_IDLE;
            end
            S_DSTEP:
            begin
                cmd.dstep  = 1'b1;
                state_next = S_DNEXT;
            end
            S_DNEXT:
            begin
                if (stat.dec_bad)
                begin
                    cmd.walk_root  = 1'b1;
                    cmd.emit_dnone = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.dec_leaf)
                begin
                    cmd.dec_leaf = 1'b1;
                    state_next   = S_DSRD;
                end
                else
                begin
                    cmd.dec_move   = 1'b1;
                    cmd.emit_dnone = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DSRD:
            begin
                cmd.dsrd   = 1'b1;
                state_next = S_DSOUT;
            end
            S_DSOUT:
            begin
                cmd.emit_dsym = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && stat.req_load && stat.last) |=> busy)
        else $error("final load request did not start a build");
`endif

endmodule

### rtl/core/huf_dp.sv
// Datapath: alphabet and tree stores, merge scan, code derivation, lookup and result registers.
module huf_dp #(
    parameter int MAX_SYMBOLS = 64,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  huf_pkg::huf_cmd_t     cmd,
    output huf_pkg::huf_stat_t    stat,
    input  logic [1:0]            req_type,
    input  logic [7:0]            symbol,
    input  logic [23:0]           weight,
    input  logic                  last_entry,
    input  logic                  code_bit,
    output logic                  result_valid,
    output logic [1:0]            result_kind,
    output logic [62:0]           code_value,
    output logic [5:0]            code_length,
    output logic                  not_found,
    output logic [7:0]            decoded_symbol,
    output logic                  symbol_valid
);

    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int IW    = $clog2(NODES);
    localparam int AW    = $clog2(MAX_SYMBOLS);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int NW    = WEIGHT_BITS + 6;
    localparam logic [63:0] WMASK64 = (64'd1 << WEIGHT_BITS) - 64'd1;

    // Stores
    logic [huf_pkg::SYM_W-1:0]  alph_mem [MAX_SYMBOLS];
    logic [NW-1:0]              wt_mem   [NODES];
    logic [IW:0]                par_mem  [NODES];
    logic [2*IW-1:0]            lr_mem   [NODES];
    logic [huf_pkg::CODE_W-1:0] code_mem [MAX_SYMBOLS];
    logic [huf_pkg::LEN_W-1:0]  len_mem  [MAX_SYMBOLS];

    logic [huf_pkg::SYM_W-1:0]  alph_rd_reg;
    logic [NW-1:0]              wt_rd_reg;
    logic [IW:0]                par_rd_reg;
    logic [2*IW-1:0]            lr_rd_reg;
    logic [huf_pkg::CODE_W-1:0] code_rd_reg;
    logic [huf_pkg::LEN_W-1:0]  len_rd_reg;

    logic [CW-1:0]              cnt_reg;
    logic                       built_reg;
    logic [IW-1:0]              walk_reg;
    logic [IW-1:0]              i_reg;
    logic [IW-1:0]              k_reg;
    logic [IW-1:0]              kd_reg;
    logic                       rdv_reg;
    logic [IW-1:0]              j_reg;
    logic [IW-1:0]              c_reg;
    logic [huf_pkg::DEPTH_W-1:0] depth_reg;
    logic [huf_pkg::CODE_W-1:0] code_reg;
    logic [IW-1:0]              a_reg;
    logic [IW-1:0]              b_reg;
    logic [NW-1:0]              wa_reg;
    logic [NW-1:0]              wb_reg;
    logic                       av_reg;
    logic                       bv_reg;
    logic                       found_reg;
    logic [IW-1:0]              fk_reg;
    logic [huf_pkg::SYM_W-1:0]  sym_reg;
    logic                       bit_reg;
    logic [IW-1:0]              cur_reg;
    logic [IW-1:0]              sidx_reg;
    logic [NODES-1:0]           hp_reg;

    logic                       rv_reg;
    logic [1:0]                 kind_reg;
    logic [huf_pkg::CODE_W-1:0] cv_reg;
    logic [huf_pkg::LEN_W-1:0]  len_reg;
    logic                       nf_reg;
    logic [huf_pkg::SYM_W-1:0]  dsym_reg;
    logic                       sval_reg;

    logic                       rv_next;
    logic [1:0]                 kind_next;
    logic [huf_pkg::CODE_W-1:0] cv_next;
    logic [huf_pkg::LEN_W-1:0]  len_next;
    logic                       nf_next;
    logic [huf_pkg::SYM_W-1:0]  dsym_next;
    logic                       sval_next;

    logic [IW-1:0]              n_node;
    logic [IW-1:0]              total;
    logic [CW-1:0]              base;
    logic                       store;
    logic [63:0]                w64;
    logic [NW-1:0]              w_ext;
    logic [NW:0]                sum;
    logic [NW-1:0]              sum_sat;
    logic                       mscan_issue;
    logic                       escan_issue;
    logic [IW-1:0]              cur_c;
    logic [IW-1:0]              nxt;
    logic [huf_pkg::LEN_W-1:0]  len_sat;
    logic                       wt_we;
    logic [IW-1:0]              wt_wa;
    logic [NW-1:0]              wt_wd;
    logic [IW-1:0]              par_wa;

    assign n_node  = IW'(cnt_reg);
    assign total   = (n_node << 1) - IW'(1);
    assign base    = built_reg ? '0 : cnt_reg;
    assign store   = (base < CW'(MAX_SYMBOLS));
    assign w64     = {40'd0, weight & WMASK64[23:0]};
    assign w_ext   = w64[NW-1:0];
    assign sum     = {1'b0, wa_reg} + {1'b0, wb_reg};
    assign sum_sat = sum[NW] ? '1 : sum[NW-1:0];
    assign mscan_issue = cmd.mscan && (k_reg < i_reg);
    assign escan_issue = cmd.escan && built_reg && (k_reg < n_node) && !found_reg;
    assign cur_c   = (walk_reg < total) ? walk_reg : total - IW'(1);
    // Child word holds the left index above the right index.
    assign nxt     = bit_reg ? lr_rd_reg[IW-1:0] : lr_rd_reg[2*IW-1:IW];
    assign len_sat = (depth_reg > huf_pkg::DEPTH_W'(huf_pkg::LEN_MAX)) ?
                     huf_pkg::LEN_MAX : depth_reg[huf_pkg::LEN_W-1:0];
    assign wt_we   = (cmd.load && store) || cmd.mw1;
    assign wt_wa   = cmd.mw1 ? i_reg : IW'(base);
    assign wt_wd   = cmd.mw1 ? sum_sat : w_ext;
    assign par_wa  = cmd.mw1 ? a_reg : b_reg;

    always_comb
    begin
        stat              = '0;
        stat.req_load     = (req_type == huf_pkg::REQ_LOAD);
        stat.req_encode   = (req_type == huf_pkg::REQ_ENCODE);
        stat.req_decode   = (req_type == huf_pkg::REQ_DECODE);
        stat.last         = last_entry;
        stat.built        = built_reg;
        stat.n_zero       = (cnt_reg == '0);
        stat.n_one        = (cnt_reg == CW'(1));
        stat.merge_end    = (i_reg == total);
        stat.scan_end     = (k_reg >= i_reg) && !rdv_reg;
        stat.leaves_end   = (j_reg == n_node);
        stat.c_has_parent = hp_reg[c_reg];
        stat.enc_hit      = found_reg;
        stat.enc_end      = (!built_reg || (k_reg >= n_node)) && !rdv_reg && !found_reg;
        stat.dec_bad      = (cur_reg < n_node) || (nxt >= total);
        stat.dec_leaf     = (nxt < n_node);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && store)
            alph_mem[AW'(base)] <= symbol;
        if (wt_we)
            wt_mem[wt_wa] <= wt_wd;
        if (cmd.mw1)
            lr_mem[i_reg] <= {a_reg, b_reg};
        // The top bit of a parent word marks a right child.
        if (cmd.mw1 || cmd.mw2)
            par_mem[par_wa] <= {cmd.mw2, i_reg};
        if (cmd.code_wr)
        begin
            code_mem[AW'(j_reg)] <= code_reg;
            len_mem[AW'(j_reg)]  <= len_sat;
        end

        if (mscan_issue)
            wt_rd_reg <= wt_mem[k_reg];
        if (escan_issue)
            alph_rd_reg <= alph_mem[AW'(k_reg)];
        else if (cmd.dsrd)
            alph_rd_reg <= alph_mem[AW'(sidx_reg)];
        if (cmd.par_rd)
            par_rd_reg <= par_mem[c_reg];
        if (cmd.dstep)
            lr_rd_reg <= lr_mem[cur_c];
        if (cmd.erd)
        begin
            code_rd_reg <= code_mem[AW'(fk_reg)];
            len_rd_reg  <= len_mem[AW'(fk_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            built_reg <= 1'b0;
            walk_reg  <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            kd_reg    <= '0;
            rdv_reg   <= 1'b0;
            j_reg     <= '0;
            c_reg     <= '0;
            depth_reg <= '0;
            code_reg  <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            wa_reg    <= '0;
            wb_reg    <= '0;
            av_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            found_reg <= 1'b0;
            fk_reg    <= '0;
            sym_reg   <= '0;
            bit_reg   <= 1'b0;
            cur_reg   <= '0;
            sidx_reg  <= '0;
            hp_reg    <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                sym_reg <= symbol;
                bit_reg <= code_bit;
            end
            // A load request after a build drops the old tree first.
            if (cmd.load)
            begin
                if (built_reg)
                begin
                    built_reg <= 1'b0;
                    walk_reg  <= '0;
                end
                cnt_reg <= store ? base + CW'(1) : base;
            end
            if (cmd.build_init)
            begin
                built_reg <= 1'b1;
                hp_reg    <= '0;
                i_reg     <= n_node;
            end
            if (cmd.scan_init)
            begin
                k_reg     <= '0;
                rdv_reg   <= 1'b0;
                av_reg    <= 1'b0;
                bv_reg    <= 1'b0;
                found_reg <= 1'b0;
            end
            if (cmd.mscan)
            begin
                rdv_reg <= mscan_issue;
                kd_reg  <= k_reg;
                if (mscan_issue)
                    k_reg <= k_reg + IW'(1);
                // Strict compares keep the lower index on equal weights.
                if (rdv_reg && !hp_reg[kd_reg])
                begin
                    if (!av_reg || (wt_rd_reg < wa_reg))
                    begin
                        b_reg  <= a_reg;
                        wb_reg <= wa_reg;
                        bv_reg <= av_reg;
                        a_reg  <= kd_reg;
                        wa_reg <= wt_rd_reg;
                        av_reg <= 1'b1;
                    end
                    else if (!bv_reg || (wt_rd_reg < wb_reg))
                    begin
                        b_reg  <= kd_reg;
                        wb_reg <= wt_rd_reg;
                        bv_reg <= 1'b1;
                    end
                end
            end
            if (cmd.escan)
            begin
                rdv_reg <= escan_issue;
                kd_reg  <= k_reg;
                if (escan_issue)
                    k_reg <= k_reg + IW'(1);
                if (rdv_reg && !found_reg && (alph_rd_reg == sym_reg))
                begin
                    found_reg <= 1'b1;
                    fk_reg    <= kd_reg;
                end
            end
            if (cmd.mw1)
                hp_reg[a_reg] <= 1'b1;
            if (cmd.mw2)
            begin
                hp_reg[b_reg] <= 1'b1;
                i_reg         <= i_reg + IW'(1);
            end
            if (cmd.code_init)
                j_reg <= '0;
            if (cmd.leaf_init)
            begin
                c_reg     <= j_reg;
                depth_reg <= '0;
                code_reg  <= '0;
            end
            // Walking towards the root, each step supplies the next higher code bit.
            if (cmd.code_up)
            begin
                if (depth_reg < huf_pkg::DEPTH_W'(huf_pkg::CODE_W))
                    code_reg[depth_reg[huf_pkg::LEN_W-1:0]] <= par_rd_reg[IW];
                depth_reg <= depth_reg + huf_pkg::DEPTH_W'(1);
                c_reg     <= par_rd_reg[IW-1:0];
            end
            if (cmd.code_wr)
                j_reg <= j_reg + IW'(1);
            if (cmd.walk_root)
                walk_reg <= (cnt_reg == '0) ? '0 : total - IW'(1);
            if (cmd.sel_first)
            begin
                sidx_reg <= '0;
                walk_reg <= '0;
            end
            if (cmd.dstep)
                cur_reg <= cur_c;
            if (cmd.dec_leaf)
            begin
                sidx_reg <= nxt;
                walk_reg <= total - IW'(1);
            end
            if (cmd.dec_move)
                walk_reg <= nxt;
        end
    end

    always_comb
    begin
        rv_next   = cmd.emit_done | cmd.emit_ehit | cmd.emit_emiss |
                    cmd.emit_dnone | cmd.emit_dsym;
        kind_next = huf_pkg::KIND_DONE;
        cv_next   = '0;
        len_next  = '0;
        nf_next   = 1'b0;
        dsym_next = '0;
        sval_next = 1'b0;
        if (cmd.emit_ehit)
        begin
            kind_next = huf_pkg::KIND_ENCODE;
            cv_next   = code_rd_reg;
            len_next  = len_rd_reg;
        end
        else if (cmd.emit_emiss)
        begin
            kind_next = huf_pkg::KIND_ENCODE;
            nf_next   = 1'b1;
        end
        else if (cmd.emit_dnone)
            kind_next = huf_pkg::KIND_DECODE;
        else if (cmd.emit_dsym)
        begin
            kind_next = huf_pkg::KIND_DECODE;
            dsym_next = alph_rd_reg;
            sval_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= rv_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        cv_reg   <= cv_next;
        len_reg  <= len_next;
        nf_reg   <= nf_next;
        dsym_reg <= dsym_next;
        sval_reg <= sval_next;
    end

    assign result_valid   = rv_reg;
    assign result_kind    = kind_reg;
    assign code_value     = cv_reg;
    assign code_length    = len_reg;
    assign not_found      = nf_reg;
    assign decoded_symbol = dsym_reg;
    assign symbol_valid   = sval_reg;

`ifndef ASSERT_OFF
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_done, cmd.emit_ehit, cmd.emit_emiss,
                  cmd.emit_dnone, cmd.emit_dsym}))
        else $error("more than one result emitted in a cycle");
    a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mw1 |-> (av_reg && bv_reg && (a_reg != b_reg)))
        else $error("merge without two distinct parentless nodes");
    a_code_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.code_up |-> $past(cmd.par_rd))
        else $error("code step without a parent read");
`endif

endmodule

### rtl/core/huffman_codec.sv
// An encode request scans the alphabet, one entry per cycle, until the symbol is found or the
// alphabet ends; a decode request moves one level down the tree for its code bit.
// The final load builds the tree: each of n-1 merges scans all nodes so far, one per cycle,
// then each leaf walks to the root one level at a time, reading each parent; done comes after that.
// One request at a time: start is taken only while busy is low.
// Reset (asynchronous, active low) empties the alphabet; results cannot be stalled.
module huffman_codec #(
    parameter int MAX_SYMBOLS = 64,
    parameter int WEIGHT_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  symbol,
    input  logic [23:0] weight,
    input  logic        last_entry,
    input  logic        code_bit,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [62:0] code_value,
    output logic [5:0]  code_length,
    output logic        not_found,
    output logic [7:0]  decoded_symbol,
    output logic        symbol_valid
);

    huf_pkg::huf_cmd_t  cmd;
    huf_pkg::huf_stat_t stat;

    huf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    huf_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .symbol         (symbol),
        .weight         (weight),
        .last_entry     (last_entry),
        .code_bit       (code_bit),
        .result_valid   (result_valid),
        .result_kind    (result_kind),
        .code_value     (code_value),
        .code_length    (code_length),
        .not_found      (not_found),
        .decoded_symbol (decoded_symbol),
        .symbol_valid   (symbol_valid)
    );

endmodule

### tb/sv/tb_top.sv
// Testbench for huffman_codec: directed table and random requests checked against a Huffman model.
`timescale 1ns / 1ps

module tb_top;

    localparam int NSYM     = 64;
    localparam int NODES    = 2 * NSYM - 1;
    localparam int NO_NODE  = -1;
    localparam longint unsigned SUM_SAT = (64'd1 << (huf_pkg::WEIGHT_W + 6)) - 64'd1;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic [1:0]  req;
        logic [7:0]  sym;
        logic [23:0] wgt;
        logic        last;
        logic        cbit;
    } huf_req_t;

    typedef struct {
        logic [1:0]  kind;
        logic [62:0] code;
        logic [5:0]  len;
        logic        nf;
        logic [7:0]  dsym;
        logic        sv;
    } huf_res_t;

    typedef struct {
        huf_req_t rq;
        bit       typed;
        huf_res_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = REQ_NONE;
    logic [7:0]  symbol = '0;
    logic [23:0] weight = '0;
    logic        last_entry = 1'b0;
    logic        code_bit = 1'b0;
    logic        result_valid;
    logic [1:0]  result_kind;
    logic [62:0] code_value;
    logic [5:0]  code_length;
    logic        not_found;
    logic [7:0]  decoded_symbol;
    logic        symbol_valid;

    huffman_codec u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .symbol(symbol), .weight(weight),
        .last_entry(last_entry), .code_bit(code_bit),
        .result_valid(result_valid), .result_kind(result_kind),
        .code_value(code_value), .code_length(code_length),
        .not_found(not_found), .decoded_symbol(decoded_symbol),
        .symbol_valid(symbol_valid)
    );

    always #4 clk = ~clk;

    // Shadow state of the codec.
    logic [7:0]      alpha [NSYM];
    longint unsigned nwt [NODES];
    int              npar [NODES];
    int              lch [NODES];
    int              rch [NODES];
    logic [62:0]     ctab [NSYM];
    logic [5:0]      ltab [NSYM];
    int              nsyms = 0;
    int              walk = 0;
    bit              tree_ok = 0;

    huf_res_t answers_q [$];
    int       errors = 0;
    int       items = 0;
    int       results_seen = 0;
    int       builds = 0;
    int       idle_pct = 0;

    function automatic void build_codes();
        int total, a, b, c, p, depth;
        longint unsigned s;
        logic [62:0] cv;
        tree_ok = 1;
        if (nsyms == 0)
        begin
            walk = 0;
            return;
        end
        total = 2 * nsyms - 1;
        for (int i = 0; i < total; i++)
        begin
            npar[i] = NO_NODE;
            lch[i] = NO_NODE;
            rch[i] = NO_NODE;
        end
        for (int i = nsyms; i < total; i++)
        begin
            a = NO_NODE;
            b = NO_NODE;
            for (int k = 0; k < i; k++)
            begin
                if (npar[k] != NO_NODE) continue;
                if (a == NO_NODE || nwt[k] < nwt[a])
                begin
                    b = a;
                    a = k;
                end
                else if (b == NO_NODE || nwt[k] < nwt[b])
                begin
                    b = k;
                end
            end
            s = nwt[a] + nwt[b];
            nwt[i] = (s > SUM_SAT) ? SUM_SAT : s;
            lch[i] = a;
            rch[i] = b;
            npar[a] = i;
            npar[b] = i;
        end
        for (int j = 0; j < nsyms; j++)
        begin
            c = j;
            p = npar[j];
            depth = 0;
            cv = '0;
            while (p != NO_NODE)
            begin
                if (depth < 63 && rch[p] == c) cv[depth] = 1'b1;
                depth++;
                c = p;
                p = npar[p];
            end
            ctab[j] = cv;
            ltab[j] = (depth > 63) ? huf_pkg::LEN_MAX : depth[5:0];
        end
        walk = total - 1;
    endfunction

    // Applies one accepted request to the shadow state; has is set when it answers.
    function automatic void huff_predict(input huf_req_t rq, output huf_res_t r, output bit has);
        int total, cur, nxt;
        r = '{kind: rq.req, code: '0, len: '0, nf: 1'b0, dsym: '0, sv: 1'b0};
        has = 1;
        case (rq.req)
            huf_pkg::REQ_LOAD:
            begin
                if (tree_ok)
                begin
                    nsyms = 0;
                    tree_ok = 0;
                    walk = 0;
                end
                if (nsyms < NSYM)
                begin
                    alpha[nsyms] = rq.sym;
                    nwt[nsyms] = 64'(rq.wgt);
                    nsyms++;
                end
                has = rq.last;
                r.kind = huf_pkg::KIND_DONE;
                if (rq.last) build_codes();
            end
            huf_pkg::REQ_ENCODE:
            begin
                r.nf = 1'b1;
                if (tree_ok)
                begin
                    for (int k = 0; k < nsyms; k++)
                    begin
                        if (alpha[k] == rq.sym)
                        begin
                            r.code = ctab[k];
                            r.len = ltab[k];
                            r.nf = 1'b0;
                            break;
                        end
                    end
                end
            end
            huf_pkg::REQ_DECODE:
            begin
                if (tree_ok && nsyms == 1)
                begin
                    r.dsym = alpha[0];
                    r.sv = 1'b1;
                    walk = 0;
                end
                else if (tree_ok && nsyms > 1)
                begin
                    total = 2 * nsyms - 1;
                    cur = (walk < total) ? walk : total - 1;
                    nxt = rq.cbit ? rch[cur] : lch[cur];
                    if (cur < nsyms || nxt < 0 || nxt >= total)
                    begin
                        walk = total - 1;
                    end
                    else if (nxt < nsyms)
                    begin
                        r.dsym = alpha[nxt];
                        r.sv = 1'b1;
                        walk = total - 1;
                    end
                    else
                    begin
                        walk = nxt;
                    end
                end
            end
            default: has = 0;
        endcase
    endfunction

    // Presents one request and holds it until the codec takes it.
    task automatic issue(input huf_req_t rq, input bit typed = 0,
                         input huf_res_t want = '{default: '0});
        huf_res_t r;
        bit has;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rq.req;
        symbol <= rq.sym;
        weight <= rq.wgt;
        last_entry <= rq.last;
        code_bit <= rq.cbit;
        do @(posedge clk); while (busy);
        huff_predict(rq, r, has);
        if (rq.req != REQ_NONE) items++;
        if (rq.req == huf_pkg::REQ_LOAD && rq.last) builds++;
        if (has) answers_q.push_back(typed ? want : r);
    endtask

    always @(posedge clk)
    begin
        huf_res_t e;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (answers_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d", $time, result_kind);
                errors++;
            end
            else
            begin
                e = answers_q.pop_front();
                if (result_kind !== e.kind)
                begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, result_kind);
                    errors++;
                end
                if (code_value !== e.code)
                begin
                    $display("%0t: code exp %h got %h", $time, e.code, code_value);
                    errors++;
                end
                if (code_length !== e.len)
                begin
                    $display("%0t: length exp %0d got %0d", $time, e.len, code_length);
                    errors++;
                end
                if (not_found !== e.nf)
                begin
                    $display("%0t: not_found exp %b got %b", $time, e.nf, not_found);
                    errors++;
                end
                if (decoded_symbol !== e.dsym)
                begin
                    $display("%0t: symbol exp %h got %h", $time, e.dsym, decoded_symbol);
                    errors++;
                end
                if (symbol_valid !== e.sv)
                begin
                    $display("%0t: symbol_valid exp %b got %b", $time, e.sv, symbol_valid);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic huf_req_t mk(input logic [1:0] rq, input logic [7:0] s,
                                    input logic [23:0] w, input logic l, input logic b);
        mk = '{req: rq, sym: s, wgt: w, last: l, cbit: b};
    endfunction

    function automatic huf_res_t ans(input logic [1:0] k, input logic [62:0] c,
                                     input logic [5:0] n, input logic nf,
                                     input logic [7:0] s, input logic sv);
        ans = '{kind: k, code: c, len: n, nf: nf, dsym: s, sv: sv};
    endfunction

    initial
    begin
        dir_row_t rows [$];
        huf_res_t none;
        logic [7:0] seq_syms [$];
        int n, phase, pool;
        none = '{default: '0};

        // Encode and decode with no tree, then a single-leaf tree, then two leaves.
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h41, 0, 0, 0), 1,
                         ans(huf_pkg::KIND_ENCODE, 0, 0, 1, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 0), 1,
                         ans(huf_pkg::KIND_DECODE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(REQ_NONE, 8'hFF, 24'hFFFFFF, 1, 1), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'h5A, 0, 1, 0), 1,
                         ans(huf_pkg::KIND_DONE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h5A, 0, 0, 0), 1,
                         ans(huf_pkg::KIND_ENCODE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h00, 0, 0, 0), 1,
                         ans(huf_pkg::KIND_ENCODE, 0, 0, 1, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 1), 1,
                         ans(huf_pkg::KIND_DECODE, 0, 0, 0, 8'h5A, 1)});
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'h41, 5, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'h42, 3, 1, 0), 1,
                         ans(huf_pkg::KIND_DONE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h42, 0, 0, 0), 1,
                         ans(huf_pkg::KIND_ENCODE, 0, 1, 0, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h41, 0, 0, 0), 1,
                         ans(huf_pkg::KIND_ENCODE, 1, 1, 0, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 1), 1,
                         ans(huf_pkg::KIND_DECODE, 0, 0, 0, 8'h41, 1)});
        // Heaviest weights, a duplicated symbol and symbol zero.
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'hFF, 24'hFFFFFF, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'h00, 24'hFFFFFF, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'hFF, 24'hFFFFFF, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'h80, 1, 1, 0), 1,
                         ans(huf_pkg::KIND_DONE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'hFF, 0, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h00, 0, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 1), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 1), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_ENCODE, 8'h80, 0, 0, 0), 0, none});
        // A load that breaks the tree, then a decode with none present.
        rows.push_back('{mk(huf_pkg::REQ_LOAD, 8'h01, 2, 0, 0), 0, none});
        rows.push_back('{mk(huf_pkg::REQ_DECODE, 0, 0, 0, 1), 1,
                         ans(huf_pkg::KIND_DECODE, 0, 0, 0, 0, 0)});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].res);

        while (items < 720)
        begin
            phase = (items / 120) % 4;
            idle_pct = (phase == 1) ? 80 : (phase == 3) ? 15 : 0;
            // Once, let everything drain before the next request.
            if (builds == 12)
            begin
                start <= 1'b0;
                while (answers_q.size() != 0) @(posedge clk);
            end
            // Mostly small alphabets; a full one and an overfull one once each.
            if (builds == 6) n = 64;
            else if (builds == 16) n = 70;
            else if ($urandom_range(19) == 0) n = 1;
            else n = $urandom_range(12, 2);
            pool = $urandom_range(1) ? 255 : 7;
            seq_syms.delete();
            for (int k = 0; k < n; k++)
            begin
                seq_syms.push_back(8'($urandom_range(pool)));
                issue(mk(huf_pkg::REQ_LOAD, seq_syms[k],
                         $urandom_range(1) ? 24'($urandom_range(15)) : 24'($urandom()),
                         k == n - 1, 1'($urandom_range(1))));
            end
            repeat ($urandom_range(40, 10))
            begin
                case ($urandom_range(19))
                    0: issue(mk(REQ_NONE, 8'($urandom()), 24'($urandom()),
                                1'($urandom()), 1'($urandom())));
                    1: issue(mk(huf_pkg::REQ_ENCODE, 8'($urandom()), 24'($urandom()),
                                1'($urandom()), 1'($urandom())));
                    2, 3, 4, 5, 6, 7:
                        issue(mk(huf_pkg::REQ_ENCODE,
                                 seq_syms[$urandom_range(seq_syms.size() - 1)],
                                 24'($urandom()), 1'($urandom()), 1'($urandom())));
                    default: issue(mk(huf_pkg::REQ_DECODE, 8'($urandom()), 24'($urandom()),
                                      0, 1'($urandom())));
                endcase
            end
            // Occasionally a stray load leaves the codec with no tree.
            if ($urandom_range(9) == 0)
            begin
                issue(mk(huf_pkg::REQ_LOAD, 8'($urandom()), 24'($urandom()), 0, 0));
                issue(mk(huf_pkg::REQ_DECODE, 0, 0, 0, 1'($urandom())));
                issue(mk(huf_pkg::REQ_ENCODE, 8'($urandom()), 0, 0, 0));
            end
        end
        start <= 1'b0;
        while (answers_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Ran %0d requests over %0d tree builds, %0d results checked.",
                 items, builds, results_seen);
        $display("Sender idling varied between none, light and heavy.");
        if (errors == 0 && answers_q.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/core/huf_pkg.sv
rtl/core/huf_ctrl.sv
rtl/core/huf_dp.sv
rtl/core/huffman_codec.sv
tb/sv/tb_top.sv
